>>> design/generational_sparse_set_store_unit_assert.svh
// assertion helpers for the entity store
`ifndef GENERATIONAL_SPARSE_SET_STORE_UNIT_ASSERT_SVH
`define GENERATIONAL_SPARSE_SET_STORE_UNIT_ASSERT_SVH

// property that holds in every cycle out of reset
`define GSSS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition in one cycle implies a condition in the next
`define GSSS_ASSERT_NEXT(lbl, cond, nxt, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) else $error(msg);

`endif

>>> design/gsss_pkg.sv
`default_nettype none
package gsss_pkg;

  localparam int SLOTS  = 1024;
  localparam int TYPES  = 8;
  localparam int IDX_W  = 10;
  localparam int CNT_W  = 11;
  localparam int GEN_W  = 16;
  localparam int DATA_W = 32;
  localparam int CID_W  = 3;
  localparam int SP_AW  = CID_W + IDX_W;
  localparam int SP_DEPTH = TYPES * SLOTS;

  localparam logic [2:0] CMD_CREATE  = 3'd0;
  localparam logic [2:0] CMD_DESTROY = 3'd1;
  localparam logic [2:0] CMD_ADD     = 3'd2;
  localparam logic [2:0] CMD_REMOVE  = 3'd3;
  localparam logic [2:0] CMD_GET     = 3'd4;
  localparam logic [2:0] CMD_ALIVE   = 3'd5;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_INVALID   = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_NO_SLOT   = 2'd3;

  localparam logic REG_TYPES = 1'b0;
  localparam logic REG_LIMIT = 1'b1;

  typedef struct packed {
    logic [2:0]        command;
    logic [IDX_W-1:0]  entity_index;
    logic [GEN_W-1:0]  entity_generation;
    logic [CID_W-1:0]  component_id;
    logic              has_data;
    logic [DATA_W-1:0] comp_data;
  } in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [IDX_W-1:0]  handle_index;
    logic [GEN_W-1:0]  handle_generation;
    logic [DATA_W-1:0] read_data;
    logic              is_alive;
  } out_t;

  typedef struct packed {
    logic [GEN_W-1:0] gen;
    logic             live;
    logic [TYPES-1:0] mask;
  } ent_t;

  typedef struct packed {
    logic [IDX_W-1:0] owner;
    logic [GEN_W-1:0] gen;
  } meta_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_ENT, S_CRD, S_SPR, S_GET, S_DWALK,
    S_DSP, S_DROP, S_MOVE, S_DFIN, S_DONE
  } state_t;

endpackage
`default_nettype wire

>>> design/generational_sparse_set_store_unit.sv
// Entity handle store: one result per command. After reset the block sweeps the entity
// table one slot a cycle and holds in_stall high meanwhile. Each command then runs on a
// sequencer around simple dual-port synchronous tables, one dependent read per cycle;
// create reads the entity table and the recycled stack, get, add and remove the sparse tables;
// destroy walks every component type and drops each component the entity holds.
// A new command is taken once the previous result sits in the output register.
`default_nettype none
module generational_sparse_set_store_unit (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire gsss_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire logic           out_stall,
  output gsss_pkg::out_t      out_data,
  input  wire logic           cfg_we,
  input  wire logic           cfg_index,
  input  wire logic [10:0]    cfg_data
);
  import gsss_pkg::*;
  `include "generational_sparse_set_store_unit_assert.svh"

  state_t state_r, state_nxt;
  in_t    in_r, in_nxt;
  ent_t   ent_r, ent_nxt;
  out_t   res_r, res_nxt, out_r;
  logic   out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0] slot_r, slot_nxt, pos_r, pos_nxt, clr_r, clr_nxt;
  logic [CID_W-1:0] c_r, c_nxt;
  logic [TYPES-1:0] mask_r, mask_nxt;
  logic [3:0]       types_r;
  logic [CNT_W-1:0] limit_r;
  logic [CNT_W-1:0] top_r, top_nxt, fresh_r, fresh_nxt, live_r, live_nxt;
  logic [CNT_W-1:0] size_r [TYPES];
  logic [CNT_W-1:0] size_nxt [TYPES];

  logic             ent_we;
  logic [IDX_W-1:0] ent_wa, ent_ra;
  ent_t             ent_wd, ent_q;
  logic             stk_we;
  logic [IDX_W-1:0] stk_wa, stk_wd, stk_ra, stk_q;
  logic             sp_we;
  logic [SP_AW-1:0] sp_wa, sp_ra;
  logic [IDX_W-1:0] sp_wd, sp_q;
  logic             dm_we;
  logic [SP_AW-1:0] dm_wa, dm_ra;
  meta_t            dm_wd, dm_q;
  logic             dp_we;
  logic [SP_AW-1:0] dp_wa, dp_ra;
  logic [DATA_W-1:0] dp_wd, dp_q;

  gsss_ram #(.DEPTH(SLOTS), .WIDTH($bits(ent_t))) u_ent (
    .clk(clk), .we(ent_we), .waddr(ent_wa), .wdata(ent_wd), .raddr(ent_ra), .rdata(ent_q));
  gsss_ram #(.DEPTH(SLOTS), .WIDTH(IDX_W)) u_stk (
    .clk(clk), .we(stk_we), .waddr(stk_wa), .wdata(stk_wd), .raddr(stk_ra), .rdata(stk_q));
  gsss_ram #(.DEPTH(SP_DEPTH), .WIDTH(IDX_W)) u_spos (
    .clk(clk), .we(sp_we), .waddr(sp_wa), .wdata(sp_wd), .raddr(sp_ra), .rdata(sp_q));
  gsss_ram #(.DEPTH(SP_DEPTH), .WIDTH($bits(meta_t))) u_dmeta (
    .clk(clk), .we(dm_we), .waddr(dm_wa), .wdata(dm_wd), .raddr(dm_ra), .rdata(dm_q));
  gsss_ram #(.DEPTH(SP_DEPTH), .WIDTH(DATA_W)) u_dpay (
    .clk(clk), .we(dp_we), .waddr(dp_wa), .wdata(dp_wd), .raddr(dp_ra), .rdata(dp_q));

  logic             alive;
  logic [CNT_W-1:0] size_c, last_c;
  logic             drop_done;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign alive = ({1'b0, in_r.entity_index} < limit_r) && ent_q.live &&
                 (ent_q.gen == in_r.entity_generation);
  assign size_c = size_r[c_r];
  assign last_c = size_c - CNT_W'(1);

  always_comb begin
    state_nxt = state_r;
    in_nxt    = in_r;
    ent_nxt   = ent_r;
    res_nxt   = res_r;
    slot_nxt  = slot_r;
    pos_nxt   = pos_r;
    clr_nxt   = clr_r;
    c_nxt     = c_r;
    mask_nxt  = mask_r;
    top_nxt   = top_r;
    fresh_nxt = fresh_r;
    live_nxt  = live_r;
    size_nxt  = size_r;
    out_valid_nxt = out_valid_r && out_stall;
    drop_done = 1'b0;
    ent_we = 1'b0; ent_wa = in_r.entity_index; ent_wd = ent_r; ent_ra = in_data.entity_index;
    stk_we = 1'b0; stk_wa = top_r[IDX_W-1:0]; stk_wd = in_r.entity_index;
    stk_ra = IDX_W'(top_r - CNT_W'(1));
    sp_we = 1'b0; sp_wa = {in_r.component_id, in_r.entity_index}; sp_wd = pos_r;
    sp_ra = {in_r.component_id, in_r.entity_index};
    dm_we = 1'b0; dm_wa = {c_r, pos_r}; dm_wd = dm_q; dm_ra = {c_r, last_c[IDX_W-1:0]};
    dp_we = 1'b0; dp_wa = {c_r, pos_r}; dp_wd = dp_q; dp_ra = {c_r, last_c[IDX_W-1:0]};

    unique case (state_r)
      S_CLEAR: begin
        ent_we = 1'b1;
        ent_wa = clr_r;
        ent_wd = '0;
        clr_nxt = clr_r + IDX_W'(1);
        if (clr_r == IDX_W'(SLOTS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          in_nxt = in_data;
          state_nxt = S_ENT;
        end
      end
      S_ENT: begin
        res_nxt = '0;
        res_nxt.status = ST_INVALID;
        ent_nxt = ent_q;
        state_nxt = S_DONE;
        unique case (in_r.command)
          CMD_CREATE: begin
            if (top_r != '0) begin
              slot_nxt = stk_q;
              top_nxt = top_r - CNT_W'(1);
              ent_ra = stk_q;
              state_nxt = S_CRD;
            end else if (fresh_r < limit_r && fresh_r < CNT_W'(SLOTS)) begin
              slot_nxt = fresh_r[IDX_W-1:0];
              fresh_nxt = fresh_r + CNT_W'(1);
              ent_ra = fresh_r[IDX_W-1:0];
              state_nxt = S_CRD;
            end else begin
              res_nxt.status = ST_NO_SLOT;
            end
          end
          CMD_DESTROY: begin
            if (alive) begin
              mask_nxt = ent_q.mask;
              c_nxt = '0;
              state_nxt = S_DWALK;
            end
          end
          CMD_ADD, CMD_REMOVE, CMD_GET: begin
            if (alive && ({1'b0, in_r.component_id} < types_r)) begin
              state_nxt = S_SPR;
            end
          end
          CMD_ALIVE: begin
            res_nxt.status = ST_OK;
            res_nxt.is_alive = alive;
          end
          default: ;
        endcase
      end
      S_CRD: begin
        ent_we = 1'b1;
        ent_wa = slot_r;
        ent_wd = ent_q;
        ent_wd.live = 1'b1;
        live_nxt = live_r + CNT_W'(1);
        res_nxt.status = ST_OK;
        res_nxt.handle_index = slot_r;
        res_nxt.handle_generation = ent_q.gen;
        state_nxt = S_DONE;
      end
      S_SPR: begin
        state_nxt = S_DONE;
        res_nxt.status = ST_OK;
        if (in_r.command == CMD_ADD) begin
          if (ent_r.mask[in_r.component_id]) begin
            dp_we = in_r.has_data;
            dp_wa = {in_r.component_id, sp_q};
            dp_wd = in_r.comp_data;
          end else if (size_r[in_r.component_id] < CNT_W'(SLOTS)) begin
            dm_we = 1'b1;
            dm_wa = {in_r.component_id, size_r[in_r.component_id][IDX_W-1:0]};
            dm_wd.owner = in_r.entity_index;
            dm_wd.gen = in_r.entity_generation;
            dp_we = 1'b1;
            dp_wa = dm_wa;
            dp_wd = in_r.has_data ? in_r.comp_data : '0;
            sp_we = 1'b1;
            sp_wd = size_r[in_r.component_id][IDX_W-1:0];
            ent_we = 1'b1;
            ent_wd = ent_r;
            ent_wd.mask[in_r.component_id] = 1'b1;
            size_nxt[in_r.component_id] = size_r[in_r.component_id] + CNT_W'(1);
          end
        end else if (!ent_r.mask[in_r.component_id]) begin
          res_nxt.status = ST_NOT_FOUND;
        end else if (in_r.command == CMD_REMOVE) begin
          c_nxt = in_r.component_id;
          pos_nxt = sp_q;
          state_nxt = S_DROP;
        end else begin
          dp_ra = {in_r.component_id, sp_q};
          state_nxt = S_GET;
        end
      end
      S_GET: begin
        res_nxt.read_data = dp_q;
        state_nxt = S_DONE;
      end
      S_DWALK: begin
        if (mask_r[c_r]) begin
          sp_ra = {c_r, in_r.entity_index};
          state_nxt = S_DSP;
        end else if (c_r == CID_W'(TYPES - 1)) begin
          state_nxt = S_DFIN;
        end else begin
          c_nxt = c_r + CID_W'(1);
        end
      end
      S_DSP: begin
        pos_nxt = sp_q;
        state_nxt = S_DROP;
      end
      S_DROP: begin
        if (pos_r != last_c[IDX_W-1:0]) begin
          state_nxt = S_MOVE;
        end else begin
          size_nxt[c_r] = last_c;
          drop_done = 1'b1;
        end
      end
      S_MOVE: begin
        // last entry fills the gap
        dm_we = 1'b1;
        dp_we = 1'b1;
        sp_we = 1'b1;
        sp_wa = {c_r, dm_q.owner};
        sp_wd = pos_r;
        size_nxt[c_r] = last_c;
        drop_done = 1'b1;
      end
      S_DFIN: begin
        ent_we = 1'b1;
        ent_wd.gen = ent_r.gen + GEN_W'(1);
        ent_wd.live = 1'b0;
        ent_wd.mask = '0;
        if (top_r < CNT_W'(SLOTS)) begin
          stk_we = 1'b1;
          top_nxt = top_r + CNT_W'(1);
        end
        if (live_r != '0) begin
          live_nxt = live_r - CNT_W'(1);
        end
        res_nxt.status = ST_OK;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (drop_done) begin
      if (in_r.command == CMD_DESTROY) begin
        if (c_r == CID_W'(TYPES - 1)) begin
          state_nxt = S_DFIN;
        end else begin
          c_nxt = c_r + CID_W'(1);
          state_nxt = S_DWALK;
        end
      end else begin
        ent_we = 1'b1;
        ent_wd = ent_r;
        ent_wd.mask[c_r] = 1'b0;
        res_nxt.status = ST_OK;
        state_nxt = S_DONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r <= '0;
      out_valid_r <= 1'b0;
      top_r <= '0;
      fresh_r <= '0;
      live_r <= '0;
      types_r <= '0;
      limit_r <= CNT_W'(SLOTS);
      for (int i = 0; i < TYPES; i++) begin
        size_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      clr_r <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      top_r <= top_nxt;
      fresh_r <= fresh_nxt;
      live_r <= live_nxt;
      size_r <= size_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_TYPES: types_r <= cfg_data[3:0];
          REG_LIMIT: limit_r <= cfg_data;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    in_r   <= in_nxt;
    ent_r  <= ent_nxt;
    res_r  <= res_nxt;
    slot_r <= slot_nxt;
    pos_r  <= pos_nxt;
    c_r    <= c_nxt;
    mask_r <= mask_nxt;
    if (state_r == S_DONE && (!out_valid_r || !out_stall)) begin
      out_r <= res_r;
    end
  end

  `GSSS_ASSERT(a_top_range, top_r <= CNT_W'(SLOTS), "recycled stack overflow")
  `GSSS_ASSERT(a_fresh_range, fresh_r <= CNT_W'(SLOTS), "fresh slot counter overflow")
  `GSSS_ASSERT(a_live_range, live_r <= CNT_W'(SLOTS), "live count overflow")
  `GSSS_ASSERT_NEXT(a_accept_seq, in_valid && !in_stall, state_r == S_ENT,
                    "accepted transaction not sequenced")
  `GSSS_ASSERT_NEXT(a_out_hold, out_valid_r && out_stall, out_valid_r && $stable(out_r),
                    "stalled result changed")

endmodule
`default_nettype wire

>>> design/gsss_ram.sv
`default_nettype none
module gsss_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire
